/* rtl/radix_limb_digit_shift_unit_macros.svh */
// ----------------------------------------------------------------------------
// Radix limb digit shift unit: assertion macros
// Shared concurrent assertion shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef RADIX_LIMB_DIGIT_SHIFT_UNIT_MACROS_SVH
`define RADIX_LIMB_DIGIT_SHIFT_UNIT_MACROS_SVH

// Assertion sampled on the rising clock, held off while reset is high.
`define RLDS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion sampled on the rising clock, checked through reset as well.
`define RLDS_ASSERT_NR(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rlds_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix limb digit shift package
// Shared types and constants for the controller and the datapath.
// ----------------------------------------------------------------------------
package rlds_pkg;

   // multiplier digit retired per cycle
   localparam int unsigned MUL_DIGIT_BITS = 4;

   localparam int unsigned CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIRECTION  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_LOW  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SCALE_HIGH = 2'd2;

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DIV  = 7'b0000010,
      ST_MLOAD = 7'b0000100,
      ST_MUL  = 7'b0001000,
      ST_SAVE = 7'b0010000,
      ST_MUL2 = 7'b0100000,
      ST_DONE = 7'b1000000
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic mul_load_first;
      logic mul_load_second;
      logic mul_step;
      logic save_res;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic dir_right;
      logic last;
      logic out_busy;
   } status_type;

endpackage

/* rtl/rlds_channels.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix limb digit shift channels
// Request, response and register write channels with valid/ready.
// ----------------------------------------------------------------------------
interface rlds_req_if #(
   parameter int unsigned LIMB_BITS = 64
) ();
   logic                 valid;
   logic                 ready;
   logic [LIMB_BITS-1:0] limb_value;
   logic                 last_limb;

   modport source (output valid, limb_value, last_limb, input ready);
   modport sink   (input valid, limb_value, last_limb, output ready);
endinterface

interface rlds_rsp_if #(
   parameter int unsigned LIMB_BITS = 64
) ();
   logic                 valid;
   logic                 ready;
   logic [LIMB_BITS-1:0] result_limb;
   logic [LIMB_BITS-1:0] carry_out;
   logic                 is_last;

   modport source (output valid, result_limb, carry_out, is_last, input ready);
   modport sink   (input valid, result_limb, carry_out, is_last, output ready);
endinterface

interface rlds_csr_if #(
   parameter int unsigned LIMB_BITS = 64
) ();
   logic                                valid;
   logic                                ready;
   logic [rlds_pkg::CSR_INDEX_BITS-1:0] index;
   logic [LIMB_BITS-1:0]                data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/rlds_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix limb digit shift controller
// Sequences divide, multiply and commit steps for one request at a time.
// ----------------------------------------------------------------------------
module rlds_ctrl #(
   parameter int unsigned LIMB_BITS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output rlds_pkg::cmd_type    cmd,
   input  rlds_pkg::status_type status
);
   import rlds_pkg::*;

   localparam int unsigned CNT_BITS  = $clog2(LIMB_BITS);
   localparam int unsigned MUL_STEPS = (LIMB_BITS + MUL_DIGIT_BITS - 1) / MUL_DIGIT_BITS;
   localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(LIMB_BITS - 1);
   localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(MUL_STEPS - 1);

   state_type           state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               cnt_in   = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in   = '0;
               state_in = ST_MLOAD;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_MLOAD: begin
            cmd.mul_load_first = 1'b1;
            state_in           = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = ST_SAVE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_SAVE: begin
            cmd.save_res = 1'b1;
            // shifted-out value of a right shift needs a second product
            if (status.dir_right && status.last) begin
               cmd.mul_load_second = 1'b1;
               state_in            = ST_MUL2;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MUL2: begin
            cmd.mul_step = 1'b1;
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!status.out_busy) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

/* rtl/rlds_dpath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix limb digit shift datapath
// Registers, restoring divider, digit-serial multiplier and output stage.
// ----------------------------------------------------------------------------
module rlds_dpath #(
   parameter int unsigned LIMB_BITS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [LIMB_BITS-1:0]                limb_value,
   input  logic                                last_limb,
   input  logic                                csr_write,
   input  logic [rlds_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [LIMB_BITS-1:0]                csr_data,
   input  rlds_pkg::cmd_type                   cmd,
   output rlds_pkg::status_type                status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [LIMB_BITS-1:0]                result_limb,
   output logic [LIMB_BITS-1:0]                carry_out,
   output logic                                is_last
);
   import rlds_pkg::*;

   localparam int unsigned D = MUL_DIGIT_BITS;

   // configuration and carried state
   logic                 dir_ff;
   logic [LIMB_BITS-1:0] scale_low_ff;
   logic [LIMB_BITS-1:0] scale_high_ff;
   logic [LIMB_BITS-1:0] carry_ff, carry_in;
   logic                 rsp_valid_ff;

   // working registers
   logic [LIMB_BITS-1:0] quo_ff, quo_in;
   logic [LIMB_BITS-1:0] rem_ff, rem_in;
   logic [LIMB_BITS-1:0] den_ff;
   logic [LIMB_BITS-1:0] acc_ff, acc_in;
   logic [LIMB_BITS-1:0] mcand_ff, mcand_in;
   logic [LIMB_BITS-1:0] mplier_ff, mplier_in;
   logic [LIMB_BITS-1:0] res_ff;
   logic                 last_ff;
   logic [LIMB_BITS-1:0] result_ff, cout_ff, cout_in;
   logic                 is_last_ff;

   logic [LIMB_BITS:0]     trial;
   logic                   fits;
   logic [LIMB_BITS:0]     diff;
   logic [LIMB_BITS+D-1:0] partial;

   // one restoring step: shift in the next numerator bit, subtract if it fits
   assign trial = {rem_ff, quo_ff[LIMB_BITS-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = trial >= {1'b0, den_ff};

   // one multiplier digit against the shifted multiplicand, wrapped to the limb
   assign partial = {{D{1'b0}}, mcand_ff} * {{LIMB_BITS{1'b0}}, mplier_ff[D-1:0]};

   always_comb begin
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      if (cmd.load) begin
         quo_in = limb_value;
         rem_in = '0;
      end else if (cmd.div_step) begin
         quo_in = {quo_ff[LIMB_BITS-2:0], fits};
         rem_in = fits ? diff[LIMB_BITS-1:0] : trial[LIMB_BITS-1:0];
      end
      if (cmd.mul_load_first) begin
         if (dir_ff) begin
            acc_in    = quo_ff;
            mcand_in  = scale_high_ff;
            mplier_in = carry_ff;
         end else begin
            acc_in    = carry_ff;
            mcand_in  = scale_low_ff;
            mplier_in = rem_ff;
         end
      end else if (cmd.mul_load_second) begin
         acc_in    = '0;
         mcand_in  = scale_high_ff;
         mplier_in = rem_ff;
      end else if (cmd.mul_step) begin
         acc_in    = acc_ff + partial[LIMB_BITS-1:0];
         mcand_in  = mcand_ff << D;
         mplier_in = mplier_ff >> D;
      end
   end

   // new carry and shifted-out value once the request is done
   always_comb begin
      carry_in = dir_ff ? rem_ff : quo_ff;
      cout_in  = dir_ff ? acc_ff : quo_ff;
      if (last_ff) begin
         carry_in = '0;
      end else begin
         cout_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff        <= 1'b0;
         scale_low_ff  <= LIMB_BITS'(1);
         scale_high_ff <= LIMB_BITS'(1);
         carry_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_DIRECTION:  dir_ff        <= csr_data[0];
               CSR_SCALE_LOW:  scale_low_ff  <= csr_data;
               CSR_SCALE_HIGH: scale_high_ff <= csr_data;
               default: begin
               end
            endcase
         end
         if (cmd.commit) begin
            carry_ff     <= carry_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      if (cmd.load) begin
         den_ff  <= dir_ff ? scale_low_ff : scale_high_ff;
         last_ff <= last_limb;
      end
      if (cmd.save_res) begin
         res_ff <= acc_ff;
      end
      if (cmd.commit) begin
         result_ff  <= res_ff;
         cout_ff    <= cout_in;
         is_last_ff <= last_ff;
      end
   end

   assign status.dir_right = dir_ff;
   assign status.last      = last_ff;
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign result_limb = result_ff;
   assign carry_out   = cout_ff;
   assign is_last     = is_last_ff;

endmodule

/* rtl/radix_limb_digit_shift_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix limb digit shift unit
// Shifts a multi-limb number in radix b^k limbs by e base-b digits.
// ----------------------------------------------------------------------------
// The unit works on one request at a time. Each request runs a restoring
// divider that retires one quotient bit per cycle, then a multiply-accumulate
// that retires a 4-bit multiplier digit per cycle, plus the accept, operand
// load, save and commit steps. The final limb of a right shift takes one more
// multiply pass for the shifted-out value. The divider is the pacing unit.
// A finished response sits in an output register, so the next request is
// taken while the sink still stalls.
// Registers are written through the csr channel, which is always ready:
// index 0 selects the direction (0 toward more significant digits, limbs
// least significant first; 1 toward less significant, limbs most significant
// first), index 1 is b^e, index 2 is b^(k-e); index 3 is ignored. Write them
// only while the unit is idle. A zero divisor yields an all-ones quotient and
// leaves the limb as remainder.
// ----------------------------------------------------------------------------
module radix_limb_digit_shift_unit #(
   parameter int unsigned LIMB_BITS = 64
) (
   input logic        clock,
   input logic        reset,
   rlds_req_if.sink   req_ch,
   rlds_rsp_if.source rsp_ch,
   rlds_csr_if.sink   csr_ch
);
   import rlds_pkg::*;

   cmd_type    cmd;
   status_type status;

   // register writes never stall
   assign csr_ch.ready = 1'b1;

   // sequence the divide, multiply and commit steps
   rlds_ctrl #(
      .LIMB_BITS (LIMB_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .cmd       (cmd),
      .status    (status)
   );

   // hold configuration, running carry, arithmetic and the response register
   rlds_dpath #(
      .LIMB_BITS (LIMB_BITS)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .limb_value  (req_ch.limb_value),
      .last_limb   (req_ch.last_limb),
      .csr_write   (csr_ch.valid),
      .csr_index   (csr_ch.index),
      .csr_data    (csr_ch.data),
      .cmd         (cmd),
      .status      (status),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (rsp_ch.valid),
      .result_limb (rsp_ch.result_limb),
      .carry_out   (rsp_ch.carry_out),
      .is_last     (rsp_ch.is_last)
   );

endmodule

/* rtl/rlds_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Radix limb digit shift checker
// Port-level assertions, bound to the top level.
// ----------------------------------------------------------------------------
`include "radix_limb_digit_shift_unit_macros.svh"

module rlds_checker #(
   parameter int unsigned LIMB_BITS = 64
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [LIMB_BITS-1:0] result_limb,
   input logic [LIMB_BITS-1:0] carry_out,
   input logic                 is_last
);

   `RLDS_ASSERT(a_rsp_valid_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid, "response dropped while stalled")
   `RLDS_ASSERT(a_rsp_data_hold, clock, reset, rsp_valid && !rsp_ready |=> $stable(result_limb) && $stable(carry_out) && $stable(is_last), "response changed while stalled")
   `RLDS_ASSERT(a_carry_only_last, clock, reset, rsp_valid && !is_last |-> carry_out == '0, "shifted-out value on a non-final limb")
   `RLDS_ASSERT(a_one_request, clock, reset, req_valid && req_ready |=> !req_ready, "request taken while another is in flight")
   `RLDS_ASSERT_NR(a_reset_clear, clock, $past(reset) |-> !rsp_valid, "response valid right after reset")

endmodule

bind radix_limb_digit_shift_unit rlds_checker #(
   .LIMB_BITS (LIMB_BITS)
) u_rlds_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_ch.valid),
   .req_ready   (req_ch.ready),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .result_limb (rsp_ch.result_limb),
   .carry_out   (rsp_ch.carry_out),
   .is_last     (rsp_ch.is_last)
);
